### hw/rtl/ofuc_pkg.sv
package ofuc_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] put_char;
  } in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       is_empty;
    logic       is_full;
  } out_t;

endpackage

### hw/rtl/overwrite_fifo_uppercase_chars.sv
// The result beat of an accepted input beat is registered and appears in the cycle after it.
// Throughput: one beat per cycle while out_ready keeps up; the ring memory takes one write or one read per cycle.
// A result waiting at the output register holds off input only when out_ready is low.
// Reset (synchronous, active low) empties the ring and the output register.
// The slot memory is not cleared and needs no clearing pass.
module overwrite_fifo_uppercase_chars (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ofuc_pkg::in_t  in_payload,
  output logic           out_valid,
  input  logic           out_ready,
  output ofuc_pkg::out_t out_payload
);

  logic [7:0] mem [ofuc_pkg::DEPTH];

  logic [ofuc_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ofuc_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic                       full_r, full_nxt;
  logic                       out_valid_r;
  logic                       hit_r;
  logic                       out_empty_r;
  logic                       out_full_r;
  logic [7:0]                 rdata_r;

  logic       in_fire;
  logic       empty_now;
  logic       do_put;
  logic       do_get;
  logic [7:0] folded;

  function automatic logic [ofuc_pkg::PTR_W-1:0] advance(
    input logic [ofuc_pkg::PTR_W-1:0] p
  );
    logic [ofuc_pkg::PTR_W-1:0] n;
    if (p == ofuc_pkg::PTR_LAST) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign empty_now = !full_r && (wr_ptr_r == rd_ptr_r);
  assign do_put    = in_fire && (in_payload.command == ofuc_pkg::CMD_PUT);
  assign do_get    = in_fire && (in_payload.command == ofuc_pkg::CMD_GET) && !empty_now;

  always_comb begin
    folded = in_payload.put_char;
    if (in_payload.put_char >= 8'h61 && in_payload.put_char <= 8'h7a) begin
      folded = in_payload.put_char - 8'h20;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    full_nxt   = full_r;
    if (in_fire) begin
      case (in_payload.command)
        ofuc_pkg::CMD_PUT: begin
          wr_ptr_nxt = advance(wr_ptr_r);
          if (full_r) begin
            rd_ptr_nxt = advance(rd_ptr_r);
          end
          full_nxt = (advance(wr_ptr_r) == (full_r ? advance(rd_ptr_r) : rd_ptr_r));
        end
        ofuc_pkg::CMD_GET: begin
          if (!empty_now) begin
            rd_ptr_nxt = advance(rd_ptr_r);
            full_nxt   = 1'b0;
          end
        end
        ofuc_pkg::CMD_CLEAR: begin
          wr_ptr_nxt = rd_ptr_r;
          full_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_put) begin
      mem[wr_ptr_r] <= folded;
    end
    if (do_get) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      out_empty_r <= 1'b1;
      out_full_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      full_r   <= full_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
        hit_r       <= do_get;
        out_empty_r <= !full_nxt && (wr_ptr_nxt == rd_ptr_nxt);
        out_full_r  <= full_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_payload.read_char = hit_r ? rdata_r : 8'h00;
  assign out_payload.is_empty  = out_empty_r;
  assign out_payload.is_full   = out_full_r;

  a_full_ptrs_equal: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wr_ptr_r == rd_ptr_r))
    else $error("Full ring with unequal pointers.");

  a_get_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_payload.command == ofuc_pkg::CMD_GET && empty_now)
      |=> (out_payload.read_char == 8'h00))
    else $error("Get on an empty ring returned a nonzero byte.");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_payload.command == ofuc_pkg::CMD_CLEAR)
      |=> (out_valid && out_payload.is_empty && !out_payload.is_full))
    else $error("Clear did not report an empty ring.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_payload.is_empty && out_payload.is_full))
    else $error("Result beat reports both empty and full.");

  a_put_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_payload.command == ofuc_pkg::CMD_PUT) |=> !empty_now)
    else $error("Ring is empty after a put.");

endmodule
